>>> rtl/core/sphere_falloff_field_query_defines.svh
// assertion macros for the sphere falloff field query block
`ifndef SPHERE_FALLOFF_FIELD_QUERY_DEFINES_SVH
`define SPHERE_FALLOFF_FIELD_QUERY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sfq_pkg.sv
// package: types, codes and sizes of the sphere falloff field query block
package sfq_pkg;

  localparam int MAX_SPHERES = 64;
  localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W = $clog2(MAX_SPHERES + 1);
  localparam int SUM_W = 17 + CNT_W;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS  = 17;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        sphere_radius;
    logic [16:0]        sphere_strength;
  } in_t;

  typedef struct packed {
    logic [16:0] field_level;
    logic        inside_any;
    logic [6:0]  assigned_id;
    logic        status;
  } out_t;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [15:0]        rad;
    logic [16:0]        str;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_TEST,
    ST_SQRT,
    ST_MULT,
    ST_DIV,
    ST_NEXT,
    ST_DONE
  } state_e;

endpackage

>>> rtl/core/sphere_falloff_field_query.sv
// top level: sphere table with a point field query over all stored spheres
// clear and add items: result strobe in the cycle after start, busy stays low
// query item: per sphere read, load, squares, test; inside: 24 sqrt + 17 divide steps
// the per-sphere cost comes from the one-bit-a-step root and divide unit
// reset clears the sphere count and restarts ids at 1; the table ram is not cleared
// results cannot be stalled: each one shows for a single cycle on done_o
`include "sphere_falloff_field_query_defines.svh"

module sphere_falloff_field_query (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  sfq_pkg::in_t item_i,
  output logic         done_o,
  output sfq_pkg::out_t result_o
);

  sfq_pkg::state_e state_q, state_d;

  // table bookkeeping
  logic [sfq_pkg::CNT_W-1:0] count_q, count_d;
  logic [sfq_pkg::CNT_W-1:0] next_id_q, next_id_d;
  logic [sfq_pkg::IDX_W-1:0] idx_q, idx_d;

  // query datapath
  logic signed [23:0] px_q, py_q, pz_q;
  logic signed [24:0] dx_q, dy_q, dz_q;
  logic [15:0]        rad_q;
  logic [16:0]        str_q;
  logic [31:0]        rsq_q;
  logic [51:0]        acc_q, acc_d;
  logic [47:0]        v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic [40:0]        rem_q, rem_d, dv_q, dv_d;
  logic [16:0]        quo_q, quo_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [sfq_pkg::SUM_W-1:0] sum_q, sum_d;
  logic               inside_q, inside_d;

  logic          done_q, done_d;
  sfq_pkg::out_t out_q, out_d;

  // ram port
  logic                        ram_we;
  logic [sfq_pkg::IDX_W-1:0]   ram_addr;
  sfq_pkg::entry_t             ram_wentry, ram_rentry;
  logic [sfq_pkg::ENTRY_W-1:0] ram_rdata;

  logic accept;
  logic is_last;
  logic table_full;
  logic signed [24:0] mul_op;
  logic signed [49:0] mul_sq;
  logic [47:0] sq_trial;
  logic [23:0] rr;
  logic [23:0] root_dist;
  logic [40:0] dv_init;
  logic [16:0] quo_next;

  assign accept     = start_i && (state_q == sfq_pkg::ST_IDLE);
  assign table_full = (count_q >= sfq_pkg::CNT_W'(sfq_pkg::MAX_SPHERES));
  assign is_last    = (sfq_pkg::CNT_W'(idx_q) + sfq_pkg::CNT_W'(1)) == count_q;
  assign ram_rentry = sfq_pkg::entry_t'(ram_rdata);

  sfq_ram #(
    .WIDTH (sfq_pkg::ENTRY_W),
    .DEPTH (sfq_pkg::MAX_SPHERES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wentry),
    .rdata_o (ram_rdata)
  );

  // add writes the next free slot, a query walks idx
  always_comb begin
    ram_we = accept && (item_i.func == sfq_pkg::FUNC_ADD) && !table_full;
    ram_addr = (state_q == sfq_pkg::ST_IDLE) ? count_q[sfq_pkg::IDX_W-1:0] : idx_q;
    ram_wentry.cx  = item_i.pos_x;
    ram_wentry.cy  = item_i.pos_y;
    ram_wentry.cz  = item_i.pos_z;
    ram_wentry.rad = item_i.sphere_radius;
    ram_wentry.str = item_i.sphere_strength;
  end

  // shared squarer, one axis per cycle
  always_comb begin
    case (state_q)
      sfq_pkg::ST_SQY: mul_op = dy_q;
      sfq_pkg::ST_SQZ: mul_op = dz_q;
      default:         mul_op = dx_q;
    endcase
    mul_sq = mul_op * mul_op;
  end

  assign rr        = {rad_q, 8'd0};
  assign sq_trial  = res_q + bit_q;
  // root never exceeds rr for a containing sphere; clamp kept for safety
  assign root_dist = (res_q > 48'(rr)) ? rr : res_q[23:0];
  assign dv_init   = 41'({rr, 16'd0});
  assign quo_next  = {quo_q[15:0], (rem_q >= dv_q)};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfq_pkg::ST_IDLE: begin
        if (accept && item_i.func == sfq_pkg::FUNC_QUERY) begin
          state_d = (count_q == '0) ? sfq_pkg::ST_DONE : sfq_pkg::ST_READ;
        end
      end
      sfq_pkg::ST_READ: state_d = sfq_pkg::ST_LOAD;
      sfq_pkg::ST_LOAD: state_d = sfq_pkg::ST_SQX;
      sfq_pkg::ST_SQX:  state_d = sfq_pkg::ST_SQY;
      sfq_pkg::ST_SQY:  state_d = sfq_pkg::ST_SQZ;
      sfq_pkg::ST_SQZ:  state_d = sfq_pkg::ST_TEST;
      sfq_pkg::ST_TEST: begin
        if (acc_q <= 52'(rsq_q) && rad_q != '0) begin
          state_d = sfq_pkg::ST_SQRT;
        end else begin
          state_d = sfq_pkg::ST_NEXT;
        end
      end
      sfq_pkg::ST_SQRT: begin
        if (cnt_q == 5'(sfq_pkg::SQRT_STEPS - 1)) begin
          state_d = sfq_pkg::ST_MULT;
        end
      end
      sfq_pkg::ST_MULT: state_d = sfq_pkg::ST_DIV;
      sfq_pkg::ST_DIV: begin
        if (cnt_q == 5'(sfq_pkg::DIV_STEPS - 1)) begin
          state_d = sfq_pkg::ST_NEXT;
        end
      end
      sfq_pkg::ST_NEXT: state_d = is_last ? sfq_pkg::ST_DONE : sfq_pkg::ST_READ;
      sfq_pkg::ST_DONE: state_d = sfq_pkg::ST_IDLE;
      default:          state_d = sfq_pkg::ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    count_d   = count_q;
    next_id_d = next_id_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    v_d       = v_q;
    res_d     = res_q;
    bit_d     = bit_q;
    rem_d     = rem_q;
    dv_d      = dv_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    inside_d  = inside_q;
    done_d    = 1'b0;
    out_d     = out_q;
    case (state_q)
      sfq_pkg::ST_IDLE: begin
        if (accept) begin
          idx_d    = '0;
          sum_d    = '0;
          inside_d = 1'b0;
          out_d    = '0;
          case (item_i.func)
            sfq_pkg::FUNC_CLEAR: begin
              count_d   = '0;
              next_id_d = sfq_pkg::CNT_W'(1);
              done_d    = 1'b1;
            end
            sfq_pkg::FUNC_ADD: begin
              if (table_full) begin
                out_d.status = 1'b1;
              end else begin
                out_d.assigned_id = next_id_q[6:0];
                count_d   = count_q + sfq_pkg::CNT_W'(1);
                next_id_d = next_id_q + sfq_pkg::CNT_W'(1);
              end
              done_d = 1'b1;
            end
            sfq_pkg::FUNC_QUERY: ;
            default: done_d = 1'b1;
          endcase
        end
      end
      sfq_pkg::ST_SQX: acc_d = 52'($unsigned(mul_sq));
      sfq_pkg::ST_SQY, sfq_pkg::ST_SQZ: acc_d = acc_q + 52'($unsigned(mul_sq));
      sfq_pkg::ST_TEST: begin
        if (acc_q <= 52'(rsq_q)) begin
          inside_d = 1'b1;
        end
        v_d   = {acc_q[31:0], 16'd0};
        res_d = '0;
        bit_d = 48'd1 << 46;
        cnt_d = '0;
      end
      sfq_pkg::ST_SQRT: begin
        if (v_q >= sq_trial) begin
          v_d   = v_q - sq_trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
      end
      sfq_pkg::ST_MULT: begin
        rem_d = str_q * (rr - root_dist);
        dv_d  = dv_init;
        quo_d = '0;
        cnt_d = '0;
      end
      sfq_pkg::ST_DIV: begin
        if (rem_q >= dv_q) begin
          rem_d = rem_q - dv_q;
        end
        dv_d  = dv_q >> 1;
        quo_d = quo_next;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(sfq_pkg::DIV_STEPS - 1)) begin
          sum_d = sum_q + sfq_pkg::SUM_W'(quo_next);
        end
      end
      sfq_pkg::ST_NEXT: idx_d = idx_q + sfq_pkg::IDX_W'(1);
      sfq_pkg::ST_DONE: begin
        out_d.field_level = (sum_q > sfq_pkg::SUM_W'(sfq_pkg::ONE_Q16)) ?
                            sfq_pkg::ONE_Q16 : sum_q[16:0];
        out_d.inside_any  = inside_q;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sfq_pkg::ST_IDLE;
      count_q   <= '0;
      next_id_q <= sfq_pkg::CNT_W'(1);
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    acc_q    <= acc_d;
    v_q      <= v_d;
    res_q    <= res_d;
    bit_q    <= bit_d;
    rem_q    <= rem_d;
    dv_q     <= dv_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    sum_q    <= sum_d;
    inside_q <= inside_d;
    out_q    <= out_d;
    if (accept) begin
      px_q <= item_i.pos_x;
      py_q <= item_i.pos_y;
      pz_q <= item_i.pos_z;
    end
    // entry arrives in the cycle after the read address
    if (state_q == sfq_pkg::ST_LOAD) begin
      dx_q  <= 25'(px_q) - 25'(ram_rentry.cx);
      dy_q  <= 25'(py_q) - 25'(ram_rentry.cy);
      dz_q  <= 25'(pz_q) - 25'(ram_rentry.cz);
      rad_q <= ram_rentry.rad;
      str_q <= ram_rentry.str;
      rsq_q <= ram_rentry.rad * ram_rentry.rad;
    end
  end

  assign busy_o   = (state_q != sfq_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = out_q;

  `SFQ_ASSERT_NOW(a_count_max, 1'b1, count_q <= sfq_pkg::CNT_W'(sfq_pkg::MAX_SPHERES), "count over max")
  `SFQ_ASSERT_NOW(a_id_tracks, 1'b1, next_id_q == count_q + sfq_pkg::CNT_W'(1), "id out of step")
  `SFQ_ASSERT_NOW(a_write_idle, ram_we, state_q == sfq_pkg::ST_IDLE, "table write while busy")
  `SFQ_ASSERT_NOW(a_root_nonzero, state_q == sfq_pkg::ST_SQRT, rad_q != '0, "root on zero radius")
  `SFQ_ASSERT_NOW(a_done_idle, done_o, state_q == sfq_pkg::ST_IDLE, "result while busy")

endmodule

>>> rtl/core/sfq_ram.sv
// generic single-port ram with registered read
module sfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
